[src/frml_pkg.sv]
// Shared types and constants for the frame rate meter and limiter.
package frml_pkg;

    localparam int FT_W          = 16;
    localparam int FT_MAX        = 65535;
    localparam int FPS_W         = 22;
    localparam int FPS_MAX       = 4194303;
    localparam int FPS_DEFAULT   = 15360;
    localparam int DELAY_W       = 10;
    localparam int CFG_W         = 10;
    localparam int MAX_FPS_RESET = 60;
    localparam int PERIOD_NUM    = 1000;
    localparam int RATE_SCALE    = 256000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_FPS_GO,
        S_FPS_WAIT,
        S_PER_GO,
        S_PER_WAIT,
        S_OUT
    } t_state;

endpackage

[src/frml_ring.sv]
// Ring memory of recent frame times, one write and one registered read port.
module frml_ring #(
    parameter int DEPTH  = 10,
    parameter int ADDR_W = 4
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [frml_pkg::FT_W-1:0]  i_wdata,
    input  logic                       i_re,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [frml_pkg::FT_W-1:0]  o_rdata
);

    logic [frml_pkg::FT_W-1:0] r_mem [DEPTH];
    logic [frml_pkg::FT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/frml_div.sv]
// Restoring divider, one quotient bit per clock.
module frml_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_sub;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
        n_rem   = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // shift quotient bits into the dividend register as it empties
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[NUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

[src/frame_rate_meter_limiter.sv]
// Top level: frame rate meter with moving-average window and frame limiter.
// One input word per frame carries the start and end millisecond ticks. The block returns
// the frame time (end minus previous end, saturated at 65535, 0 on the first frame), the
// average rate over the last WINDOW_LEN frame times in Q8 (15360 while the window sum is
// zero) and the delay that holds the max_fps target. Frame times live in a ring memory
// that is read and written back once per word. The one bit-serial divider, NUM_W bits wide
// (NUM_W is the width of 256000*WINDOW_LEN), computes the rate and then the target period;
// the rate division is skipped while the window sum is zero. A new word is taken only once
// the previous one is fully computed; the result register lets it enter while the last
// result still waits downstream.
module frame_rate_meter_limiter #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [frml_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [31:0]                   i_frame_start_ms,
    input  logic [31:0]                   i_frame_end_ms,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [frml_pkg::FT_W-1:0]     o_frame_time_ms,
    output logic [frml_pkg::FPS_W-1:0]    o_fps_q8,
    output logic [frml_pkg::DELAY_W-1:0]  o_delay_ms
);

    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = $clog2(WINDOW_LEN * frml_pkg::FT_MAX + 1);
    localparam int NUM_W  = $clog2(WINDOW_LEN * frml_pkg::RATE_SCALE + 1);
    localparam int QX_W   = (NUM_W > frml_pkg::FPS_W) ? NUM_W : frml_pkg::FPS_W;

    frml_pkg::t_state                r_state;
    frml_pkg::t_state                n_state;

    logic [frml_pkg::CFG_W-1:0]      r_max_fps;
    logic [31:0]                     r_prev_end;
    logic                            r_have_prev;
    logic [SLOT_W-1:0]               r_slot;
    logic [FILL_W-1:0]               r_fill;
    logic [SUM_W-1:0]                r_sum;
    logic [frml_pkg::FT_W-1:0]       r_ft;
    logic [31:0]                     r_elapsed;
    logic [frml_pkg::FPS_W-1:0]      r_fps;
    logic [frml_pkg::DELAY_W-1:0]    r_delay;

    logic                            r_out_valid;
    logic [frml_pkg::FT_W-1:0]       r_out_ft;
    logic [frml_pkg::FPS_W-1:0]      r_out_fps;
    logic [frml_pkg::DELAY_W-1:0]    r_out_delay;

    logic                            accept;
    logic                            ring_we;
    logic [frml_pkg::FT_W-1:0]       ring_rdata;
    logic [31:0]                     diff;
    logic [frml_pkg::FT_W-1:0]       n_ft;
    logic [SUM_W-1:0]                n_sum;
    logic [FILL_W-1:0]               n_fill;
    logic [SLOT_W-1:0]               n_slot;
    logic                            ring_full;
    logic                            out_free;

    logic                            div_start;
    logic                            div_busy;
    logic                            div_done;
    logic [NUM_W-1:0]                div_num;
    logic [SUM_W-1:0]                div_den;
    logic [NUM_W-1:0]                div_quot;
    logic [QX_W-1:0]                 quot_ext;
    logic [frml_pkg::CFG_W-1:0]      fps_lim;
    logic [frml_pkg::DELAY_W-1:0]    period;
    logic [frml_pkg::FPS_W-1:0]      fps_sat;
    logic [frml_pkg::DELAY_W-1:0]    delay_calc;

    frml_ring #(
        .DEPTH  (WINDOW_LEN),
        .ADDR_W (SLOT_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_slot),
        .i_wdata (r_ft),
        .i_re    (accept),
        .i_raddr (r_slot),
        .o_rdata (ring_rdata)
    );

    frml_div #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            frml_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = frml_pkg::S_UPD;
                end
            end
            frml_pkg::S_UPD: begin
                n_state = frml_pkg::S_FPS_GO;
            end
            frml_pkg::S_FPS_GO: begin
                n_state = (r_sum == '0) ? frml_pkg::S_PER_GO : frml_pkg::S_FPS_WAIT;
            end
            frml_pkg::S_FPS_WAIT: begin
                if (div_done) begin
                    n_state = frml_pkg::S_PER_GO;
                end
            end
            frml_pkg::S_PER_GO: begin
                n_state = frml_pkg::S_PER_WAIT;
            end
            frml_pkg::S_PER_WAIT: begin
                if (div_done) begin
                    n_state = frml_pkg::S_OUT;
                end
            end
            frml_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = frml_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = frml_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_ready   = 1'b0;
        ring_we   = 1'b0;
        div_start = 1'b0;
        div_num   = NUM_W'(frml_pkg::PERIOD_NUM);
        div_den   = SUM_W'(fps_lim);
        case (r_state)
            frml_pkg::S_IDLE: begin
                o_ready = 1'b1;
            end
            frml_pkg::S_UPD: begin
                ring_we = 1'b1;
            end
            frml_pkg::S_FPS_GO: begin
                div_start = (r_sum != '0);
                div_num   = NUM_W'(int'(r_fill) * frml_pkg::RATE_SCALE);
                div_den   = r_sum;
            end
            frml_pkg::S_PER_GO: begin
                div_start = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        accept    = i_valid && o_ready;
        out_free  = !r_out_valid || i_ready;
        diff      = i_frame_end_ms - r_prev_end;
        if (!r_have_prev) begin
            n_ft = '0;
        end else if (diff > 32'(frml_pkg::FT_MAX)) begin
            n_ft = frml_pkg::FT_W'(frml_pkg::FT_MAX);
        end else begin
            n_ft = diff[frml_pkg::FT_W-1:0];
        end

        // drop the oldest time once the window is full
        ring_full = (r_fill == FILL_W'(WINDOW_LEN));
        if (ring_full) begin
            n_sum  = r_sum - SUM_W'(ring_rdata) + SUM_W'(r_ft);
            n_fill = r_fill;
        end else begin
            n_sum  = r_sum + SUM_W'(r_ft);
            n_fill = r_fill + FILL_W'(1);
        end
        n_slot = (r_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : r_slot + SLOT_W'(1);

        fps_lim  = (r_max_fps == '0) ? frml_pkg::CFG_W'(1) : r_max_fps;
        quot_ext = QX_W'(div_quot);
        fps_sat  = (quot_ext > QX_W'(frml_pkg::FPS_MAX))
                 ? frml_pkg::FPS_W'(frml_pkg::FPS_MAX) : quot_ext[frml_pkg::FPS_W-1:0];
        period   = div_quot[frml_pkg::DELAY_W-1:0];
        delay_calc = (32'(period) > r_elapsed)
                   ? period - r_elapsed[frml_pkg::DELAY_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= frml_pkg::S_IDLE;
            r_max_fps   <= frml_pkg::CFG_W'(frml_pkg::MAX_FPS_RESET);
            r_prev_end  <= '0;
            r_have_prev <= 1'b0;
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_max_fps <= i_cfg_wdata;
            end
            if (accept) begin
                r_prev_end  <= i_frame_end_ms;
                r_have_prev <= 1'b1;
            end
            if (ring_we) begin
                r_sum  <= n_sum;
                r_fill <= n_fill;
                r_slot <= n_slot;
            end
            if (r_state == frml_pkg::S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ft      <= n_ft;
            r_elapsed <= i_frame_end_ms - i_frame_start_ms;
        end
        if (r_state == frml_pkg::S_FPS_GO && r_sum == '0) begin
            r_fps <= frml_pkg::FPS_W'(frml_pkg::FPS_DEFAULT);
        end else if (r_state == frml_pkg::S_FPS_WAIT && div_done) begin
            r_fps <= fps_sat;
        end
        if (r_state == frml_pkg::S_PER_WAIT && div_done) begin
            r_delay <= delay_calc;
        end
        if (r_state == frml_pkg::S_OUT && out_free) begin
            r_out_ft    <= r_ft;
            r_out_fps   <= r_fps;
            r_out_delay <= r_delay;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_frame_time_ms = r_out_ft;
    assign o_fps_q8        = r_out_fps;
    assign o_delay_ms      = r_out_delay;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW_LEN))
        else $error("fill count above window length");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(WINDOW_LEN - 1))
        else $error("write slot outside ring");

    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_sum == '0))
        else $error("window sum nonzero with empty ring");

    a_accept_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == frml_pkg::S_UPD))
        else $error("accepted word did not reach ring update");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == frml_pkg::S_FPS_WAIT || r_state == frml_pkg::S_PER_WAIT))
        else $error("divider finished outside a wait state");

    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == frml_pkg::S_IDLE) |-> !div_busy)
        else $error("divider busy while idle");
`endif

endmodule

[tb/frame_rate_meter_limiter_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the frame rate meter and limiter, with its own frame predictor.
module frame_rate_meter_limiter_tb;

    localparam int WINDOW_LEN       = 10;
    localparam int NUM_PHASES       = 7;
    localparam int RANDOM_PER_PHASE = 140;
    localparam int SETTLE_CYCLES    = 64;
    localparam int STALL_LIMIT      = 4000;
    localparam int REPORT_LIMIT     = 10;
    localparam int RESET_CYCLES     = 8;

    typedef struct packed {
        logic [31:0] begin_ms;
        logic [31:0] finish_ms;
    } t_frame_stamp;

    typedef struct packed {
        logic [frml_pkg::FT_W-1:0]    frame_time;
        logic [frml_pkg::FPS_W-1:0]   fps;
        logic [frml_pkg::DELAY_W-1:0] delay;
    } t_frame_report;

    logic                         i_clk            = 1'b0;
    logic                         i_rst_n          = 1'b0;
    logic                         i_cfg_we         = 1'b0;
    logic [frml_pkg::CFG_W-1:0]   i_cfg_wdata      = '0;
    logic                         i_valid          = 1'b0;
    logic                         o_ready;
    logic [31:0]                  i_frame_start_ms = '0;
    logic [31:0]                  i_frame_end_ms   = '0;
    logic                         o_valid;
    logic                         i_ready          = 1'b0;
    logic [frml_pkg::FT_W-1:0]    o_frame_time_ms;
    logic [frml_pkg::FPS_W-1:0]   o_fps_q8;
    logic [frml_pkg::DELAY_W-1:0] o_delay_ms;

    frame_rate_meter_limiter #(
        .WINDOW_LEN (WINDOW_LEN)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_frame_start_ms (i_frame_start_ms),
        .i_frame_end_ms   (i_frame_end_ms),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_frame_time_ms  (o_frame_time_ms),
        .o_fps_q8         (o_fps_q8),
        .o_delay_ms       (o_delay_ms)
    );

    always #1 i_clk = ~i_clk;

    t_frame_stamp  frame_stamps_q[$];
    t_frame_report report_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // Predictor state
    logic [frml_pkg::CFG_W-1:0] target_fps = frml_pkg::CFG_W'(frml_pkg::MAX_FPS_RESET);
    logic [31:0]                last_end   = '0;
    logic                       seen_frame = 1'b0;
    logic [frml_pkg::FT_W-1:0]  ft_ring[WINDOW_LEN];
    int                         ring_slot  = 0;
    int                         ring_fill  = 0;
    logic [19:0]                ring_sum   = '0;

    // Stimulus generator state
    logic [31:0] gen_end  = '0;
    int          zero_run = 0;

    function automatic t_frame_report advance_meter(logic [31:0] begin_ms,
                                                    logic [31:0] finish_ms);
        t_frame_report     rep;
        logic [31:0]       gap;
        logic [31:0]       busy;
        logic [31:0]       period;
        longint unsigned   rate;
        gap = finish_ms - last_end;
        if (!seen_frame)
            rep.frame_time = '0;
        else if (gap > frml_pkg::FT_MAX)
            rep.frame_time = frml_pkg::FT_W'(frml_pkg::FT_MAX);
        else
            rep.frame_time = gap[frml_pkg::FT_W-1:0];
        last_end   = finish_ms;
        seen_frame = 1'b1;

        // Drop the oldest frame time once the window is full
        if (ring_fill == WINDOW_LEN)
            ring_sum = ring_sum - 20'(ft_ring[ring_slot]);
        else
            ring_fill++;
        ft_ring[ring_slot] = rep.frame_time;
        ring_sum  = ring_sum + 20'(rep.frame_time);
        ring_slot = (ring_slot == WINDOW_LEN - 1) ? 0 : ring_slot + 1;

        if (ring_sum == 0) begin
            rate = frml_pkg::FPS_DEFAULT;
        end else begin
            rate = (longint'(ring_fill) * frml_pkg::RATE_SCALE) / ring_sum;
            if (rate > frml_pkg::FPS_MAX)
                rate = frml_pkg::FPS_MAX;
        end
        rep.fps = rate[frml_pkg::FPS_W-1:0];

        period = frml_pkg::PERIOD_NUM / ((target_fps == 0) ? 1 : target_fps);
        busy   = finish_ms - begin_ms;
        rep.delay = (period > busy) ? frml_pkg::DELAY_W'(period - busy) : '0;
        return rep;
    endfunction

    task automatic queue_frame(input logic [31:0] begin_ms, input logic [31:0] finish_ms);
        frame_stamps_q.push_back('{begin_ms, finish_ms});
    endtask

    task automatic queue_random_frames(input int count);
        int          kind;
        logic [31:0] gap;
        logic [31:0] busy;
        repeat (count) begin
            kind = $urandom_range(99);
            if (zero_run == 0 && kind < 5)
                zero_run = $urandom_range(3, 12);
            if (kind >= 93) begin
                gen_end = $urandom;
                queue_frame($urandom, gen_end);
            end else begin
                if (zero_run > 0) begin
                    gap = '0;
                    zero_run--;
                end else if (kind < 10) begin
                    gap = $urandom_range(60000, 70000);
                end else begin
                    gap = $urandom_range(1, 60);
                end
                busy = $urandom_range(1) ? $urandom_range(0, 40) : $urandom_range(0, 1100);
                gen_end = gen_end + gap;
                queue_frame(gen_end - busy, gen_end);
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (frame_stamps_q.size() != 0 || i_valid || report_q.size() != 0);
    endtask

    // Driver: offer one word at a time, hold it until taken
    always @(posedge i_clk) begin
        t_frame_stamp stamp;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                report_q.push_back(advance_meter(i_frame_start_ms, i_frame_end_ms));
            if (!i_valid || o_ready) begin
                if (frame_stamps_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    stamp = frame_stamps_q.pop_front();
                    i_valid          <= 1'b1;
                    i_frame_start_ms <= stamp.begin_ms;
                    i_frame_end_ms   <= stamp.finish_ms;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, check each result word against the oldest prediction
    always @(posedge i_clk) begin
        t_frame_report got_report;
        t_frame_report exp_report;
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            got_report = '{o_frame_time_ms, o_fps_q8, o_delay_ms};
            if (report_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected word: ft %0d fps %0d delay %0d",
                             got_report.frame_time, got_report.fps, got_report.delay);
            end else begin
                exp_report = report_q.pop_front();
                if (got_report !== exp_report) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: ft %0d/%0d fps %0d/%0d delay %0d/%0d (exp/got)",
                                 exp_report.frame_time, got_report.frame_time,
                                 exp_report.fps, got_report.fps,
                                 exp_report.delay, got_report.delay);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        logic [frml_pkg::CFG_W-1:0] cfg_value;
        int k;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames at the reset rate target
        queue_frame(32'd0, 32'd0);
        queue_frame(32'd0, 32'd0);
        queue_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_frame(32'hFFFF_FFF0, 32'h0000_000A);
        queue_frame(32'd20, 32'd26);
        queue_frame(32'd26, 32'd42);
        queue_frame(32'd42, 32'd57);
        queue_frame(32'd100, 32'd50);
        for (k = 1; k <= 13; k++)
            queue_frame(32'd50 + 16 * k - k, 32'd50 + 16 * k);
        gen_end = 32'd50 + 16 * 13;
        queue_random_frames(RANDOM_PER_PHASE);

        for (int p = 1; p < NUM_PHASES; p++) begin
            // Hold new words until every pending result is back
            wait_drained();
            case (p)
                1: begin cfg_value = 10'd1;    send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin cfg_value = 10'd1000; send_idle_pct = 0;  recv_stall_pct = 56; end
                3: begin cfg_value = 10'd0;    send_idle_pct = 22; recv_stall_pct = 22; end
                4: begin cfg_value = 10'd1023; send_idle_pct = 0;  recv_stall_pct = 0;  end
                5: begin
                    cfg_value = frml_pkg::CFG_W'($urandom_range(2, 999));
                    send_idle_pct = 56; recv_stall_pct = 0;
                end
                default: begin
                    cfg_value = frml_pkg::CFG_W'($urandom_range(2, 999));
                    send_idle_pct = 22; recv_stall_pct = 22;
                end
            endcase
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= cfg_value;
            @(posedge i_clk);
            i_cfg_we   <= 1'b0;
            target_fps = cfg_value;
            @(negedge i_clk);
            // Cross the 2^32 tick wrap with well-formed frames
            if (p == 3)
                gen_end = 32'hFFFF_FE00;
            queue_random_frames(RANDOM_PER_PHASE);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (report_q.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
src/frml_pkg.sv
src/frml_ring.sv
src/frml_div.sv
src/frame_rate_meter_limiter.sv
tb/frame_rate_meter_limiter_tb.sv
